### sv/rgb16_pkg.sv
package rgb16_pkg;

  localparam int PixelW = 8;
  localparam int QuoW = 6;
  localparam int RemW = PixelW + QuoW;
  localparam int IndexW = 4;

  localparam logic [PixelW-1:0] ChromaMin = 8'd12;
  localparam logic [PixelW-1:0] LDark = 8'd127;
  localparam logic [PixelW-1:0] LBright = 8'd235;
  localparam logic [PixelW-1:0] GBlack = 8'd63;
  localparam logic [PixelW-1:0] GDgray = 8'd159;
  localparam logic [PixelW-1:0] GLgray = 8'd223;
  localparam logic [7:0] HueSpan = 8'd192;
  localparam logic [7:0] HueWrap = 8'd176;
  localparam logic [7:0] HueHalfStep = 8'd16;

  localparam logic [1:0] SectRed = 2'd0;
  localparam logic [1:0] SectGreen = 2'd1;
  localparam logic [1:0] SectBlue = 2'd2;

  localparam logic [IndexW-1:0] IdxBlack = 4'd0;
  localparam logic [IndexW-1:0] IdxLgray = 4'd7;
  localparam logic [IndexW-1:0] IdxDgray = 4'd8;
  localparam logic [IndexW-1:0] IdxWhite = 4'd15;

  typedef struct packed {
    logic              is_color;
    logic              neg;
    logic [1:0]        base;
    logic [PixelW-1:0] lt;
    logic [PixelW-1:0] ch;
    logic [RemW-1:0]   rem;
    logic [QuoW-1:0]   quo;
  } rgb16_work_t;

  function automatic logic [2:0] sector_color(input logic [2:0] sector);
    logic [2:0] color;
    case (sector)
      3'd0: color = 3'd1;
      3'd1: color = 3'd3;
      3'd2: color = 3'd2;
      3'd3: color = 3'd6;
      3'd4: color = 3'd4;
      3'd5: color = 3'd5;
      default: color = 3'd1;
    endcase
    return color;
  endfunction

endpackage

### sv/rgb_to_16_color_index.sv
// A request accepted at the input passes the front register, the divider stages and the
// back register before it shows on out_tvalid. Throughput: one pixel per cycle while
// out_tready is high; three pipelined divider stages of two quotient bits each set the
// depth, and every stage holds its item while the next one is full. Reset: rst_n low at
// a clock edge clears every stage valid bit; the data registers are not reset.
module rgb_to_16_color_index (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // red [7:0], green [15:8], blue [23:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // palette_index [3:0], zero [7:4]
);
  import rgb16_pkg::*;

  localparam int DivStages = 3;

  logic        vld [DivStages+1];
  logic        rdy [DivStages+1];
  rgb16_work_t work [DivStages+1];
  logic        back_rdy;
  logic [3:0]  palette_index;

  rgb16_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_vld   (in_tvalid),
    .up_rdy   (in_tready),
    .red      (in_tdata[7:0]),
    .green    (in_tdata[15:8]),
    .blue     (in_tdata[23:16]),
    .vld      (vld[0]),
    .down_rdy (rdy[0]),
    .data     (work[0])
  );

  for (genvar s = 0; s < DivStages; s++) begin : g_div
    rgb16_div_stage u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_vld   (vld[s]),
      .up_rdy   (rdy[s]),
      .up_data  (work[s]),
      .vld      (vld[s+1]),
      .down_rdy (rdy[s+1]),
      .data     (work[s+1])
    );
  end

  assign rdy[DivStages] = back_rdy;

  rgb16_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .up_vld        (vld[DivStages]),
    .up_rdy        (back_rdy),
    .up_data       (work[DivStages]),
    .vld           (out_tvalid),
    .down_rdy      (out_tready),
    .palette_index (palette_index)
  );

  assign out_tdata = {4'b0, palette_index};

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled while the pipeline has room");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7:4] == 4'b0)
    else $error("output padding bits set");

endmodule

### sv/rgb16_front.sv
module rgb16_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       up_vld,
  output logic                       up_rdy,
  input  logic [7:0]                 red,
  input  logic [7:0]                 green,
  input  logic [7:0]                 blue,
  output logic                       vld,
  input  logic                       down_rdy,
  output rgb16_pkg::rgb16_work_t     data
);
  import rgb16_pkg::*;

  logic              vld_r;
  rgb16_work_t       data_r;
  rgb16_work_t       data_nxt;
  logic [PixelW-1:0] mx;
  logic [PixelW-1:0] mn;
  logic [PixelW:0]   lsum;
  logic [PixelW-1:0] pa;
  logic [PixelW-1:0] pb;
  logic [PixelW-1:0] mag;

  always_comb begin
    mx = red;
    if (green > mx) mx = green;
    if (blue > mx) mx = blue;
    mn = red;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
    lsum = {1'b0, mx} + {1'b0, mn};
    if (mx == red) begin
      pa = green;
      pb = blue;
      data_nxt.base = SectRed;
    end else if (mx == green) begin
      pa = blue;
      pb = red;
      data_nxt.base = SectGreen;
    end else begin
      pa = red;
      pb = green;
      data_nxt.base = SectBlue;
    end
    data_nxt.neg = pa < pb;
    mag = (pa < pb) ? (pb - pa) : (pa - pb);
    data_nxt.ch = mx - mn;
    data_nxt.lt = lsum[PixelW:1];
    data_nxt.is_color = (mx - mn) >= ChromaMin;
    data_nxt.rem = {1'b0, mag, 5'b0};
    data_nxt.quo = '0;
  end

  assign up_rdy = !vld_r || down_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_rdy) begin
      vld_r <= up_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (up_rdy && up_vld) begin
      data_r <= data_nxt;
    end
  end

  assign vld = vld_r;
  assign data = data_r;

endmodule

### sv/rgb16_div_stage.sv
module rgb16_div_stage (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       up_vld,
  output logic                       up_rdy,
  input  rgb16_pkg::rgb16_work_t     up_data,
  output logic                       vld,
  input  logic                       down_rdy,
  output rgb16_pkg::rgb16_work_t     data
);
  import rgb16_pkg::*;

  logic            vld_r;
  rgb16_work_t     data_r;
  rgb16_work_t     data_nxt;
  logic [RemW-1:0] dsr;
  logic [RemW-1:0] rem;
  logic [QuoW-1:0] quo;

  // Two restoring steps, each producing one quotient bit.
  always_comb begin
    dsr = {1'b0, up_data.ch, 5'b0};
    rem = up_data.rem;
    quo = up_data.quo;
    for (int i = 0; i < 2; i++) begin
      if (rem >= dsr) begin
        rem = rem - dsr;
        quo = {quo[QuoW-2:0], 1'b1};
      end else begin
        quo = {quo[QuoW-2:0], 1'b0};
      end
      rem = {rem[RemW-2:0], 1'b0};
    end
    data_nxt = up_data;
    data_nxt.rem = rem;
    data_nxt.quo = quo;
  end

  assign up_rdy = !vld_r || down_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_rdy) begin
      vld_r <= up_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (up_rdy && up_vld) begin
      data_r <= data_nxt;
    end
  end

  assign vld = vld_r;
  assign data = data_r;

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r && data_r.is_color |-> data_r.rem < {data_r.ch, 6'b0})
    else $error("partial remainder out of range");

endmodule

### sv/rgb16_back.sv
module rgb16_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       up_vld,
  output logic                       up_rdy,
  input  rgb16_pkg::rgb16_work_t     up_data,
  output logic                       vld,
  input  logic                       down_rdy,
  output logic [3:0]                 palette_index
);
  import rgb16_pkg::*;

  logic              vld_r;
  logic [IndexW-1:0] idx_r;
  logic [IndexW-1:0] idx_nxt;
  logic [9:0]        hsum;
  logic [9:0]        qext;
  logic [7:0]        hue;
  logic [7:0]        hshift;
  logic [2:0]        sector;
  logic [2:0]        color;

  always_comb begin
    qext = {4'b0, up_data.quo};
    hsum = {2'b0, up_data.base, 6'b0} + (up_data.neg ? (10'd0 - qext) : qext);
    if (hsum[9]) begin
      hue = hsum[7:0] + HueSpan;
    end else begin
      hue = hsum[7:0];
    end
    hshift = hue + HueHalfStep;
    sector = (hue < HueWrap) ? hshift[7:5] : 3'd0;
    color = sector_color(sector);
    if (up_data.is_color) begin
      if (up_data.lt < LDark) begin
        idx_nxt = {1'b0, color};
      end else if (up_data.lt < LBright) begin
        idx_nxt = {1'b1, color};
      end else begin
        idx_nxt = IdxWhite;
      end
    end else if (up_data.lt < GBlack) begin
      idx_nxt = IdxBlack;
    end else if (up_data.lt < GDgray) begin
      idx_nxt = IdxDgray;
    end else if (up_data.lt < GLgray) begin
      idx_nxt = IdxLgray;
    end else begin
      idx_nxt = IdxWhite;
    end
  end

  assign up_rdy = !vld_r || down_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_rdy) begin
      vld_r <= up_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (up_rdy && up_vld) begin
      idx_r <= idx_nxt;
    end
  end

  assign vld = vld_r;
  assign palette_index = idx_r;

  a_quo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    up_vld && up_data.is_color |-> up_data.quo <= 6'd32)
    else $error("hue quotient above one sector step");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    up_vld && up_data.is_color |-> up_data.rem < {up_data.ch, 6'b0})
    else $error("final remainder out of range");

endmodule
